// ----- src/i2p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg: shared definitions for the infix-to-postfix converter
// Character codes, operator codes, size constants and the operator ranking.
// ----------------------------------------------------------------------------
package i2p_pkg;

    // Default operator stack depth.
    localparam int STACK_DEPTH_DEF = 16;

    // Maximum number of result transactions produced by one input transaction.
    localparam int MAX_RESULTS = 32;

    // Stored result entry: [7:0] value, [8] kind, [9] token-start mark.
    localparam int RES_W = 10;

    // Delimiter and prefix characters.
    localparam logic [7:0] CH_T      = 8'h74; // 't'
    localparam logic [7:0] CH_R      = 8'h72; // 'r'
    localparam logic [7:0] CH_S      = 8'h73; // 's'
    localparam logic [7:0] CH_Q      = 8'h71; // 'q'
    localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D; // '-'
    localparam logic [7:0] CH_TIMES  = 8'h2A; // '*'
    localparam logic [7:0] CH_OPEN   = 8'h28; // '('
    localparam logic [7:0] CH_CLOSE  = 8'h29; // ')'

    // Operator stack codes, as they also appear in the token stream.
    localparam logic [2:0] CODE_PLUS  = 3'd0;
    localparam logic [2:0] CODE_MINUS = 3'd1;
    localparam logic [2:0] CODE_TIMES = 3'd2;
    localparam logic [2:0] CODE_TR    = 3'd3;
    localparam logic [2:0] CODE_SQRT  = 3'd4;
    localparam logic [2:0] CODE_PAREN = 3'd5;

    // Binding strength on the stack: parenthesis lowest, then functions,
    // then plus and minus, then times.
    function automatic logic [1:0] op_rank(input logic [2:0] code);
        logic [1:0] r;
        case (code)
            CODE_PAREN:          r = 2'd0;
            CODE_TR, CODE_SQRT:  r = 2'd1;
            CODE_TIMES:          r = 2'd3;
            default:             r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// ----- src/i2p_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value when no read is requested.
// ----------------------------------------------------------------------------
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/infix_to_postfix_converter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: streaming shunting-yard converter
// A character that only fills the lookahead is taken in its accept cycle. Otherwise
// the byte is accepted, each decided byte passes S_DECIDE and S_NEXT, each stack pop
// takes its own step, a further step ends each operator, close parenthesis and the
// flush, and each result is read (S_DRD) and then loaded (S_DLOAD). One input
// transaction is processed at a time; s_axis_tready is high only in S_IDLE.
// Reset clears the sequencer, lookahead, stack count, name and error state.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    input  logic        s_axis_tlast,   // in_last
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] tok_value, [8] err_flag, [15:9] zero
    output logic        m_axis_tlast,   // run_last
    output logic [1:0]  m_axis_tuser    // [0] tok_kind, [1] tok_first
);

    // Stack sizing: the count must reach STACK_DEPTH itself, the index not.
    localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    // Result buffer sizing.
    localparam int RCNT_W = $clog2(i2p_pkg::MAX_RESULTS + 1);
    localparam int RADR_W = $clog2(i2p_pkg::MAX_RESULTS);
    localparam int RES_W  = i2p_pkg::RES_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0; // waiting for a transaction
    localparam logic [2:0] S_DECIDE = 3'd1; // classify the byte at the window head
    localparam logic [2:0] S_POPOP  = 3'd2; // pop operators ranked at least as high, then push
    localparam logic [2:0] S_CLOSE  = 3'd3; // close parenthesis handling
    localparam logic [2:0] S_NEXT   = 3'd4; // next byte, flush or keep lookahead
    localparam logic [2:0] S_FLUSH  = 3'd5; // empty the stack at end of expression
    localparam logic [2:0] S_DRD    = 3'd6; // read a buffered result
    localparam logic [2:0] S_DLOAD  = 3'd7; // move it into the output register

    logic [2:0]  state_reg, state_next;

    // Lookahead that survives between transactions.
    logic [7:0]  la_buf_reg [4];
    logic [7:0]  la_buf_next [4];
    logic [2:0]  la_cnt_reg, la_cnt_next;

    // Working window of the current transaction: lookahead plus new byte.
    logic [7:0]  win_reg [5];
    logic [7:0]  win_next [5];
    logic [2:0]  len_reg, len_next;
    logic [2:0]  pos_reg, pos_next;
    logic        last_reg, last_next;

    // Operator stack. Entries above the count are never read.
    logic [2:0]        op_stack_reg [STACK_DEPTH];
    logic [SCNT_W-1:0] stk_cnt_reg, stk_cnt_next;

    logic        in_name_reg, in_name_next;
    logic        err_reg, err_next;
    logic [2:0]  code_reg, code_next;

    // Result buffer bookkeeping.
    logic [RCNT_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic [RCNT_W-1:0] rd_idx_reg, rd_idx_next;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    logic [RES_W-1:0] m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             m_err_reg, m_err_next;

    // Window bytes past the valid length read as zero, which never matches
    // a prefix character, so the prefix compares need no length checks.
    logic [7:0]  win_ext [10];
    logic [7:0]  b0, b1, b2, b3, b4;

    logic [SIDX_W-1:0] top_idx;
    logic [2:0]        stk_top;
    logic              stk_empty;
    logic              stk_full;

    // Shared stack and emitter controls.
    logic              push_en;
    logic [2:0]        push_code;
    logic              pop_en;
    logic              emit_en;
    logic [RES_W-1:0]  emit_data;
    logic              ram_we;
    logic              ram_re;
    logic [RES_W-1:0]  ram_rdata;

    logic              is_tr;
    logic              is_sqrt;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            if (3'(i) < len_reg)
            begin
                win_ext[i] = win_reg[i];
            end
            else
            begin
                win_ext[i] = 8'h00;
            end
        end
        for (int i = 5; i < 10; i++)
        begin
            win_ext[i] = 8'h00;
        end
    end

    assign b0 = win_ext[4'(pos_reg)];
    assign b1 = win_ext[4'(pos_reg) + 4'd1];
    assign b2 = win_ext[4'(pos_reg) + 4'd2];
    assign b3 = win_ext[4'(pos_reg) + 4'd3];
    assign b4 = win_ext[4'(pos_reg) + 4'd4];

    assign is_tr   = (b0 == i2p_pkg::CH_T) && (b1 == i2p_pkg::CH_R) &&
                     (b2 == i2p_pkg::CH_OPEN);
    assign is_sqrt = (b0 == i2p_pkg::CH_S) && (b1 == i2p_pkg::CH_Q) &&
                     (b2 == i2p_pkg::CH_R) && (b3 == i2p_pkg::CH_T) &&
                     (b4 == i2p_pkg::CH_OPEN);

    assign stk_empty = (stk_cnt_reg == '0);
    assign stk_full  = (stk_cnt_reg == SCNT_W'(STACK_DEPTH));
    assign top_idx   = stk_empty ? '0 : SIDX_W'(stk_cnt_reg - 1'b1);
    assign stk_top   = op_stack_reg[top_idx];

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        la_buf_next  = la_buf_reg;
        la_cnt_next  = la_cnt_reg;
        win_next     = win_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        in_name_next = in_name_reg;
        err_next     = err_reg;
        code_next    = code_reg;
        rd_idx_next  = rd_idx_reg;
        push_en      = 1'b0;
        push_code    = i2p_pkg::CODE_PAREN;
        pop_en       = 1'b0;
        emit_en      = 1'b0;
        emit_data    = '0;
        ram_re       = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;

        // The output register empties when its transaction is taken.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (!s_axis_tlast && la_cnt_reg < 3'd4)
                    begin
                        // Not enough lookahead yet: just store the byte.
                        la_buf_next[la_cnt_reg[1:0]] = s_axis_tdata;
                        la_cnt_next = la_cnt_reg + 3'd1;
                    end
                    else
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            if (3'(i) < la_cnt_reg)
                            begin
                                win_next[i] = la_buf_reg[i];
                            end
                            else if (3'(i) == la_cnt_reg)
                            begin
                                win_next[i] = s_axis_tdata;
                            end
                            else
                            begin
                                win_next[i] = 8'h00;
                            end
                        end
                        len_next   = la_cnt_reg + 3'd1;
                        pos_next   = 3'd0;
                        last_next  = s_axis_tlast;
                        rd_idx_next = '0;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_NEXT;
                if (is_tr)
                begin
                    in_name_next = 1'b0;
                    push_en      = 1'b1;
                    push_code    = i2p_pkg::CODE_TR;
                    pos_next     = pos_reg + 3'd3;
                end
                else if (is_sqrt)
                begin
                    in_name_next = 1'b0;
                    push_en      = 1'b1;
                    push_code    = i2p_pkg::CODE_SQRT;
                    pos_next     = pos_reg + 3'd5;
                end
                else if (b0 == i2p_pkg::CH_PLUS || b0 == i2p_pkg::CH_MINUS ||
                         b0 == i2p_pkg::CH_TIMES)
                begin
                    in_name_next = 1'b0;
                    pos_next     = pos_reg + 3'd1;
                    state_next   = S_POPOP;
                    if (b0 == i2p_pkg::CH_PLUS)
                    begin
                        code_next = i2p_pkg::CODE_PLUS;
                    end
                    else if (b0 == i2p_pkg::CH_MINUS)
                    begin
                        code_next = i2p_pkg::CODE_MINUS;
                    end
                    else
                    begin
                        code_next = i2p_pkg::CODE_TIMES;
                    end
                end
                else if (b0 == i2p_pkg::CH_OPEN)
                begin
                    in_name_next = 1'b0;
                    push_en      = 1'b1;
                    push_code    = i2p_pkg::CODE_PAREN;
                    pos_next     = pos_reg + 3'd1;
                end
                else if (b0 == i2p_pkg::CH_CLOSE)
                begin
                    in_name_next = 1'b0;
                    pos_next     = pos_reg + 3'd1;
                    state_next   = S_CLOSE;
                end
                else
                begin
                    // Name character; only the first of a name starts a token.
                    emit_en      = 1'b1;
                    emit_data    = {~in_name_reg, 1'b0, b0};
                    in_name_next = 1'b1;
                    pos_next     = pos_reg + 3'd1;
                end
            end
            S_POPOP:
            begin
                if (!stk_empty &&
                    i2p_pkg::op_rank(code_reg) <= i2p_pkg::op_rank(stk_top))
                begin
                    pop_en = 1'b1;
                end
                else
                begin
                    push_en    = 1'b1;
                    push_code  = code_reg;
                    state_next = S_NEXT;
                end
            end
            S_CLOSE:
            begin
                if (!stk_empty && stk_top <= i2p_pkg::CODE_TIMES)
                begin
                    pop_en = 1'b1;
                end
                else if (stk_empty)
                begin
                    // Unmatched close parenthesis: flag it and drop it.
                    err_next   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    // Remove the opener; a function opener is emitted.
                    pop_en     = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (last_reg)
                begin
                    state_next = (pos_reg < len_reg) ? S_DECIDE : S_FLUSH;
                end
                else
                begin
                    // Keep the undecided bytes as lookahead.
                    for (int i = 0; i < 4; i++)
                    begin
                        la_buf_next[i] = win_ext[4'(pos_reg) + 4'(i)];
                    end
                    la_cnt_next = len_reg - pos_reg;
                    state_next  = (wr_cnt_reg == '0) ? S_IDLE : S_DRD;
                end
            end
            S_FLUSH:
            begin
                if (!stk_empty)
                begin
                    pop_en = 1'b1;
                end
                else
                begin
                    in_name_next = 1'b0;
                    la_cnt_next  = 3'd0;
                    state_next   = (wr_cnt_reg == '0) ? S_IDLE : S_DRD;
                end
            end
            S_DRD:
            begin
                ram_re     = 1'b1;
                state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = ram_rdata;
                    m_last_next  = (rd_idx_reg == wr_cnt_reg - 1'b1);
                    m_err_next   = err_reg;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    state_next   = (rd_idx_reg == wr_cnt_reg - 1'b1) ? S_IDLE : S_DRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A pop emits the removed code. A plain parenthesis opener is only
        // emitted when the flush finds it still open.
        if (pop_en && (stk_top != i2p_pkg::CODE_PAREN || state_reg == S_FLUSH))
        begin
            emit_en   = 1'b1;
            emit_data = {1'b1, 1'b1, 5'd0, stk_top};
        end
        if (push_en && stk_full)
        begin
            err_next = 1'b1;
        end
    end

    // Stack count and the write of a result into the buffer.
    always_comb
    begin
        stk_cnt_next = stk_cnt_reg;
        if (pop_en)
        begin
            stk_cnt_next = stk_cnt_reg - 1'b1;
        end
        else if (push_en && !stk_full)
        begin
            stk_cnt_next = stk_cnt_reg + 1'b1;
        end

        // A new transaction restarts the buffer; overflowing results are dropped.
        ram_we      = emit_en && (wr_cnt_reg < RCNT_W'(i2p_pkg::MAX_RESULTS));
        wr_cnt_next = wr_cnt_reg;
        if (state_reg == S_IDLE && state_next == S_DECIDE)
        begin
            wr_cnt_next = '0;
        end
        else if (ram_we)
        begin
            wr_cnt_next = wr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en && !stk_full)
        begin
            op_stack_reg[SIDX_W'(stk_cnt_reg)] <= push_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            for (int i = 0; i < 4; i++)
            begin
                la_buf_reg[i] <= 8'h00;
            end
            la_cnt_reg  <= 3'd0;
            len_reg     <= 3'd0;
            pos_reg     <= 3'd0;
            last_reg    <= 1'b0;
            stk_cnt_reg <= '0;
            in_name_reg <= 1'b0;
            err_reg     <= 1'b0;
            wr_cnt_reg  <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            la_buf_reg  <= la_buf_next;
            la_cnt_reg  <= la_cnt_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            last_reg    <= last_next;
            stk_cnt_reg <= stk_cnt_next;
            in_name_reg <= in_name_next;
            err_reg     <= err_next;
            wr_cnt_reg  <= wr_cnt_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        code_reg   <= code_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
    end

    // Results of one input transaction are held here until the transaction
    // is fully processed, so every result carries the final error state.
    i2p_ram #(
        .WIDTH (RES_W),
        .DEPTH (i2p_pkg::MAX_RESULTS)
    ) u_res_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_cnt_reg[RADR_W-1:0]),
        .wdata (emit_data),
        .re    (ram_re),
        .raddr (rd_idx_reg[RADR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_err_reg, m_data_reg[7:0]};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = {m_data_reg[9], m_data_reg[8]};

endmodule

// ----- test/infix_to_postfix_converter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb: self-checking bench for the converter
// Streams infix expressions in, one character per transaction, and predicts
// the postfix token stream with a behavioral shunting-yard model of its own.
// Every output transaction is compared against the oldest prediction while
// both stream sides idle at random. The receiver holds off for a long stretch
// once, and the sender drains between phases.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top_tb;

    localparam int DEPTH            = i2p_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int DRAIN_CYCLES     = 100;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AT     = 60;
    localparam int PHASE_A_CHARS    = 230;
    localparam int TARGET_CHARS     = 430;

    // One infix character as it waits for the driver.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } infix_char_t;

    // One postfix token, with the flags the block attaches to it.
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       first;
        logic       run_last;
        logic       err;
    } token_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_char
    logic        s_axis_tlast = 1'b0;    // in_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] tok_value, [8] err_flag, [15:9] zero
    logic        m_axis_tlast;           // run_last
    logic [1:0]  m_axis_tuser;           // [0] tok_kind, [1] tok_first

    infix_to_postfix_converter_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the lookahead window, the operator stack, whether a
    // name is in progress, and the sticky error.
    // ------------------------------------------------------------------------
    logic [7:0] la_buf [4];
    int         la_count;
    logic [2:0] op_stack [DEPTH];
    int         sp;
    logic       name_open;
    logic       err_sticky;
    logic [7:0] window_bytes [5];

    token_t      step_tokens[$];      // tokens caused by the character being converted
    token_t      expected_tokens[$];  // tokens predicted but not yet seen at the output
    infix_char_t char_fifo[$];        // characters waiting for the driver
    logic [7:0]  expr_bytes[$];       // expression under construction

    int    chars_queued = 0;
    int    tokens_seen;
    int    error_count = 0;
    int    cycle_count = 0;
    string name_chars = "abcqrstxyz09 /_";

    // Tokens beyond the per-character maximum are dropped, as the block does.
    function automatic void emit_token(logic kind, logic [7:0] value, logic first);
        token_t t;
        if (step_tokens.size() < i2p_pkg::MAX_RESULTS)
        begin
            t.kind     = kind;
            t.value    = value;
            t.first    = first;
            t.run_last = 1'b0;
            t.err      = 1'b0;
            step_tokens.push_back(t);
        end
    endfunction

    // Binding strength on the stack: open parenthesis, functions, plus and
    // minus, times, from weakest to strongest.
    function automatic int bind_strength(logic [2:0] code);
        int s;
        if (code == i2p_pkg::CODE_PAREN)
            s = 0;
        else if (code == i2p_pkg::CODE_TR || code == i2p_pkg::CODE_SQRT)
            s = 1;
        else if (code == i2p_pkg::CODE_TIMES)
            s = 3;
        else
            s = 2;
        return s;
    endfunction

    // A push onto a full stack is dropped and flags the error.
    function automatic void push_operator(logic [2:0] code);
        if (sp >= DEPTH)
            err_sticky = 1'b1;
        else
        begin
            op_stack[sp] = code;
            sp++;
        end
    endfunction

    // Pop binary operators down to the nearest open parenthesis or function.
    // A function that closes the group is emitted; finding neither is an error.
    function automatic void close_group();
        while (sp > 0 && op_stack[sp - 1] <= i2p_pkg::CODE_TIMES)
        begin
            sp--;
            emit_token(1'b1, {5'b0, op_stack[sp]}, 1'b1);
        end
        if (sp == 0)
            err_sticky = 1'b1;
        else
        begin
            sp--;
            if (op_stack[sp] == i2p_pkg::CODE_TR || op_stack[sp] == i2p_pkg::CODE_SQRT)
                emit_token(1'b1, {5'b0, op_stack[sp]}, 1'b1);
        end
    endfunction

    // Decide the byte at position 'at' of the window, with 'len' bytes left
    // from there. Returns how many bytes the decision consumed.
    function automatic int decide_window_byte(int at, int len);
        logic [7:0] c;
        logic [2:0] code;
        int         used;
        c    = window_bytes[at];
        used = 1;
        if (c == i2p_pkg::CH_T && len >= 3 && window_bytes[at + 1] == i2p_pkg::CH_R
                && window_bytes[at + 2] == i2p_pkg::CH_OPEN)
        begin
            name_open = 1'b0;
            push_operator(i2p_pkg::CODE_TR);
            used = 3;
        end
        else if (c == i2p_pkg::CH_S && len >= 5 && window_bytes[at + 1] == i2p_pkg::CH_Q
                && window_bytes[at + 2] == i2p_pkg::CH_R
                && window_bytes[at + 3] == i2p_pkg::CH_T
                && window_bytes[at + 4] == i2p_pkg::CH_OPEN)
        begin
            name_open = 1'b0;
            push_operator(i2p_pkg::CODE_SQRT);
            used = 5;
        end
        else if (c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS || c == i2p_pkg::CH_TIMES)
        begin
            name_open = 1'b0;
            code = (c == i2p_pkg::CH_PLUS) ? i2p_pkg::CODE_PLUS :
                   (c == i2p_pkg::CH_MINUS) ? i2p_pkg::CODE_MINUS : i2p_pkg::CODE_TIMES;
            while (sp > 0 && bind_strength(code) <= bind_strength(op_stack[sp - 1]))
            begin
                sp--;
                emit_token(1'b1, {5'b0, op_stack[sp]}, 1'b1);
            end
            push_operator(code);
        end
        else if (c == i2p_pkg::CH_OPEN)
        begin
            name_open = 1'b0;
            push_operator(i2p_pkg::CODE_PAREN);
        end
        else if (c == i2p_pkg::CH_CLOSE)
        begin
            name_open = 1'b0;
            close_group();
        end
        else
        begin
            emit_token(1'b0, c, !name_open);
            name_open = 1'b1;
        end
        return used;
    endfunction

    // Convert one accepted character and append its tokens to the expected
    // stream. A byte is decided once four more follow it; the last character
    // decides everything left in the window and then empties the stack.
    function automatic void convert_char(logic [7:0] ch, logic last);
        int     len;
        int     pos;
        token_t t;
        step_tokens.delete();
        for (int i = 0; i < la_count; i++)
            window_bytes[i] = la_buf[i];
        window_bytes[la_count] = ch;
        len = la_count + 1;
        pos = 0;
        if (last)
        begin
            while (pos < len)
                pos += decide_window_byte(pos, len - pos);
            while (sp > 0)
            begin
                sp--;
                emit_token(1'b1, {5'b0, op_stack[sp]}, 1'b1);
            end
            name_open = 1'b0;
            la_count  = 0;
        end
        else
        begin
            if (len == 5)
                pos = decide_window_byte(0, len);
            la_count = len - pos;
            for (int i = 0; i < la_count; i++)
                la_buf[i] = window_bytes[pos + i];
        end
        // The end-of-run mark and the error state as it stands after the step.
        foreach (step_tokens[k])
        begin
            t          = step_tokens[k];
            t.run_last = (k == step_tokens.size() - 1);
            t.err      = err_sticky;
            expected_tokens.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Expression construction.
    // ------------------------------------------------------------------------
    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++)
            expr_bytes.push_back(s[i]);
    endfunction

    // Hand the expression to the driver with the last flag on its final byte.
    function automatic void send_expr();
        infix_char_t item;
        foreach (expr_bytes[i])
        begin
            item.ch   = expr_bytes[i];
            item.last = (i == expr_bytes.size() - 1);
            char_fifo.push_back(item);
        end
        chars_queued += expr_bytes.size();
        expr_bytes.delete();
    endfunction

    function automatic logic is_delimiter(logic [7:0] c);
        return c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS || c == i2p_pkg::CH_TIMES
               || c == i2p_pkg::CH_OPEN || c == i2p_pkg::CH_CLOSE;
    endfunction

    // Names are mostly drawn from a small alphabet that shares letters with
    // the function prefixes; now and then any non-delimiter byte appears.
    function automatic void gen_name();
        int         n;
        logic [7:0] c;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                c = 8'($urandom_range(0, 255));
                while (is_delimiter(c))
                    c = 8'($urandom_range(0, 255));
            end
            else
                c = name_chars[$urandom_range(0, name_chars.len() - 1)];
            expr_bytes.push_back(c);
        end
    endfunction

    function automatic void gen_operand(int depth);
        int pick;
        pick = (depth > 0) ? $urandom_range(0, 9) : 9;
        case (pick)
            0, 1:
            begin
                append_text("(");
                gen_expr(depth - 1);
                append_text(")");
            end
            2:
            begin
                append_text("tr(");
                gen_expr(depth - 1);
                append_text(")");
            end
            3:
            begin
                append_text("sqrt(");
                gen_expr(depth - 1);
                append_text(")");
            end
            default:
                gen_name();
        endcase
    endfunction

    function automatic void gen_expr(int depth);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                case ($urandom_range(0, 2))
                    0:       expr_bytes.push_back(i2p_pkg::CH_PLUS);
                    1:       expr_bytes.push_back(i2p_pkg::CH_MINUS);
                    default: expr_bytes.push_back(i2p_pkg::CH_TIMES);
                endcase
            end
            gen_operand(depth);
        end
    endfunction

    // Pause the sender until every predicted token has been seen.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (char_fifo.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the queued characters, waits a random number of cycles
    // before each one except in burst stretches, and runs the predictor on
    // every accepted transaction.
    // ------------------------------------------------------------------------
    int          send_gap;
    logic        send_burst;
    infix_char_t next_char;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            send_gap      = 0;
            send_burst    = 1'b0;
            la_count      = 0;
            sp            = 0;
            name_open     = 1'b0;
            err_sticky    = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                convert_char(s_axis_tdata, s_axis_tlast);
                if ($urandom_range(0, 15) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 10);
            end
            // Only move on once the current transaction has gone through.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (char_fifo.size() > 0)
                begin
                    next_char = char_fifo.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_char.ch;
                    s_axis_tlast  <= next_char.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each output transaction against the oldest prediction
    // and draws a random hold-off after it. Once, a long hold-off lets the
    // block fill up and stall its input while the driver keeps offering.
    // ------------------------------------------------------------------------
    int     hold_left;
    logic   recv_burst;
    logic   long_hold_done;
    token_t got_token;
    token_t want_token;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready  <= 1'b0;
            hold_left      = 0;
            recv_burst     = 1'b0;
            long_hold_done = 1'b0;
            tokens_seen    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_token.kind     = m_axis_tuser[0];
                got_token.value    = m_axis_tdata[7:0];
                got_token.first    = m_axis_tuser[1];
                got_token.run_last = m_axis_tlast;
                got_token.err      = m_axis_tdata[8];
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token, expected none, ", $time,
                             "actual kind=%0b value=%h first=%0b last=%0b err=%0b",
                             got_token.kind, got_token.value, got_token.first,
                             got_token.run_last, got_token.err);
                    error_count++;
                end
                else
                begin
                    want_token = expected_tokens.pop_front();
                    if (got_token !== want_token)
                    begin
                        $display("%0t: token %0d mismatch, ", $time, tokens_seen,
                                 "expected kind=%0b value=%h first=%0b last=%0b err=%0b, ",
                                 want_token.kind, want_token.value, want_token.first,
                                 want_token.run_last, want_token.err,
                                 "actual kind=%0b value=%h first=%0b last=%0b err=%0b",
                                 got_token.kind, got_token.value, got_token.first,
                                 got_token.run_last, got_token.err);
                        error_count++;
                    end
                end
                tokens_seen++;
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
                hold_left = recv_burst ? 0 : $urandom_range(0, 10);
                if (!long_hold_done && tokens_seen == LONG_HOLD_AT)
                begin
                    hold_left      = LONG_HOLD_CYCLES;
                    long_hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int pick;

        // Directed expressions: plus and times inside an unmatched open
        // parenthesis that is left for the flush; a square root whose
        // group is still open at the end; extreme and odd name bytes ending in
        // a partial function prefix, which stays a name; and a complete
        // function prefix that arrives only in the flush.
        append_text("(a+b*c");
        send_expr();
        append_text("sqrt(y-z");
        send_expr();
        expr_bytes.push_back(8'h00);
        append_text("/ ");
        expr_bytes.push_back(8'hFF);
        append_text("*tr");
        send_expr();
        append_text("x*tr(");
        send_expr();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Well-formed random expressions with nested groups and functions,
        // then one nest that fills the stack exactly.
        while (chars_queued < PHASE_A_CHARS)
        begin
            gen_expr($urandom_range(0, 3));
            send_expr();
        end
        repeat (DEPTH) append_text("(");
        append_text("a");
        repeat (DEPTH) append_text(")");
        send_expr();
        wait_drained();

        // Error cases: a close parenthesis with nothing open, one after a
        // name, and a push onto a full stack. The flag must then stay set
        // for the expressions that follow.
        append_text(")");
        send_expr();
        append_text("a)*b");
        send_expr();
        repeat (DEPTH + 1) append_text("(");
        append_text("a");
        send_expr();
        append_text("tr(a)+b");
        send_expr();
        wait_drained();

        // Mostly well-formed expressions, plus raw byte noise and expressions
        // broken by a dropped byte or a stray delimiter.
        while (chars_queued < TARGET_CHARS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                gen_expr($urandom_range(0, 3));
            else if (pick < 8)
            begin
                repeat ($urandom_range(1, 8))
                    expr_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                gen_expr($urandom_range(1, 2));
                if ($urandom_range(0, 1) == 0 && expr_bytes.size() > 1)
                    expr_bytes.delete($urandom_range(0, expr_bytes.size() - 1));
                else
                    expr_bytes.insert($urandom_range(0, expr_bytes.size()),
                                      ($urandom_range(0, 1) == 0) ? i2p_pkg::CH_OPEN
                                                                  : i2p_pkg::CH_CLOSE);
            end
            send_expr();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_tokens.size() != 0)
        begin
            $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
            error_count++;
        end
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
